@@ src/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  // Kind of work handed from the decoder to the emitter
  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_PAIR   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Code point limits
  localparam logic [20:0] CP_MIN_3BYTE  = 21'h000800;
  localparam logic [20:0] CP_SURR_LOW   = 21'h00D800;
  localparam logic [20:0] CP_SURR_HIGH  = 21'h00DFFF;
  localparam logic [20:0] CP_MIN_4BYTE  = 21'h010000;
  localparam logic [20:0] CP_MAX        = 21'h10FFFF;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LOW  = 8'hC2;
  localparam logic [7:0] LEAD2_HIGH = 8'hDF;
  localparam logic [7:0] LEAD3_LOW  = 8'hE0;
  localparam logic [7:0] LEAD3_HIGH = 8'hEF;
  localparam logic [7:0] LEAD4_LOW  = 8'hF0;
  localparam logic [7:0] LEAD4_HIGH = 8'hF4;

  // Surrogate prefixes (top six bits of a high and a low surrogate)
  localparam logic [5:0] HIGH_SURR_PREFIX = 6'b110110;
  localparam logic [5:0] LOW_SURR_PREFIX  = 6'b110111;

  // One queued item of work: a single unit, a surrogate pair or an error
  typedef struct packed {
    logic [1:0]  kind;
    logic        fin;
    logic [15:0] unit_hi;   // single unit, or high surrogate
    logic [15:0] unit_lo;   // low surrogate
  } entry_t;

endpackage

@@ src/u8u16_decode.sv @@
// Front end: accepts UTF-8 bytes, tracks sequence state and classifies results.
module u8u16_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  input  logic                queue_full,
  output logic                push,
  output u8u16_pkg::entry_t   push_entry
);

  logic [20:0] partial_point, partial_point_next;
  logic [1:0]  bytes_due, bytes_due_next;
  logic [1:0]  sequence_length, sequence_length_next;
  logic        discarding, discarding_next;

  logic        accept;
  logic        emit_ok;
  logic        fail;
  logic [20:0] cp;
  logic [20:0] assembled;
  logic [1:0]  due_dec;
  logic [19:0] offset;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign assembled  = {partial_point[14:0], data_byte[5:0]};
  assign due_dec    = bytes_due - 2'd1;
  assign offset     = 20'(cp - u8u16_pkg::CP_MIN_4BYTE);

  // Sequence decoding
  always_comb begin
    partial_point_next   = partial_point;
    bytes_due_next       = bytes_due;
    sequence_length_next = sequence_length;
    discarding_next      = discarding;
    emit_ok              = 1'b0;
    fail                 = 1'b0;
    cp                   = 21'd0;

    if (discarding) begin
      if (final_byte) begin
        discarding_next      = 1'b0;
        partial_point_next   = '0;
        bytes_due_next       = '0;
        sequence_length_next = '0;
      end
    end else if (bytes_due == 2'd0) begin
      if (!data_byte[7]) begin
        cp      = {13'd0, data_byte};
        emit_ok = 1'b1;
      end else if (data_byte >= u8u16_pkg::LEAD2_LOW && data_byte <= u8u16_pkg::LEAD2_HIGH) begin
        partial_point_next   = {16'd0, data_byte[4:0]};
        bytes_due_next       = 2'd1;
        sequence_length_next = 2'd1;
        fail                 = final_byte;
      end else if (data_byte >= u8u16_pkg::LEAD3_LOW && data_byte <= u8u16_pkg::LEAD3_HIGH) begin
        partial_point_next   = {17'd0, data_byte[3:0]};
        bytes_due_next       = 2'd2;
        sequence_length_next = 2'd2;
        fail                 = final_byte;
      end else if (data_byte >= u8u16_pkg::LEAD4_LOW && data_byte <= u8u16_pkg::LEAD4_HIGH) begin
        partial_point_next   = {18'd0, data_byte[2:0]};
        bytes_due_next       = 2'd3;
        sequence_length_next = 2'd3;
        fail                 = final_byte;
      end else begin
        fail = 1'b1;
      end
    end else begin
      if (data_byte[7:6] != 2'b10) begin
        fail = 1'b1;
      end else begin
        partial_point_next = assembled;
        bytes_due_next     = due_dec;
        if (due_dec != 2'd0) begin
          fail = final_byte;
        end else begin
          cp = assembled;
          // range checks on the completed code point
          if (sequence_length == 2'd2) begin
            fail = (cp < u8u16_pkg::CP_MIN_3BYTE) ||
                   (cp >= u8u16_pkg::CP_SURR_LOW && cp <= u8u16_pkg::CP_SURR_HIGH);
          end else if (sequence_length == 2'd3) begin
            fail = (cp < u8u16_pkg::CP_MIN_4BYTE) || (cp > u8u16_pkg::CP_MAX);
          end
          emit_ok = !fail;
        end
      end
    end

    // a finished character or an error ends the sequence
    if (emit_ok || fail) begin
      partial_point_next   = '0;
      bytes_due_next       = '0;
      sequence_length_next = '0;
    end
    if (fail) begin
      discarding_next = !final_byte;
    end
  end

  // Queue entry
  always_comb begin
    push_entry.fin     = final_byte;
    push_entry.unit_hi = cp[15:0];
    push_entry.unit_lo = '0;
    if (fail) begin
      push_entry.kind    = u8u16_pkg::KIND_ERROR;
      push_entry.unit_hi = '0;
    end else if (cp[20:16] != 5'd0) begin
      push_entry.kind    = u8u16_pkg::KIND_PAIR;
      push_entry.unit_hi = {u8u16_pkg::HIGH_SURR_PREFIX, offset[19:10]};
      push_entry.unit_lo = {u8u16_pkg::LOW_SURR_PREFIX, offset[9:0]};
    end else begin
      push_entry.kind = u8u16_pkg::KIND_SINGLE;
    end
  end

  assign push = accept && (emit_ok || fail);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point   <= '0;
      bytes_due       <= '0;
      sequence_length <= '0;
      discarding      <= 1'b0;
    end else if (accept) begin
      partial_point   <= partial_point_next;
      bytes_due       <= bytes_due_next;
      sequence_length <= sequence_length_next;
      discarding      <= discarding_next;
    end
  end

endmodule

@@ src/u8u16_fifo.sv @@
// Small register queue of decoded entries between front and back end.
module u8u16_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8u16_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output u8u16_pkg::entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  u8u16_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ src/u8u16_emit.sv @@
// Back end: turns queued entries into UTF-16 result items, one per cycle while out_ready allows.
module u8u16_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  u8u16_pkg::entry_t head_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       code_unit,
  output logic              run_last,
  output logic              error,
  output logic              stream_end
);

  logic        second;      // high surrogate of the head pair already sent
  logic        load;
  logic        take;
  logic [15:0] unit_next;
  logic        last_next, err_next, end_next;

  assign load = !out_valid || out_ready;
  assign take = head_valid && load;
  assign pop  = take && (head_entry.kind != u8u16_pkg::KIND_PAIR || second);

  // Result fields for the head entry
  always_comb begin
    unique case (head_entry.kind)
      u8u16_pkg::KIND_ERROR: begin
        unit_next = '0;
        last_next = 1'b1;
        err_next  = 1'b1;
        end_next  = 1'b1;
      end
      u8u16_pkg::KIND_PAIR: begin
        unit_next = second ? head_entry.unit_lo : head_entry.unit_hi;
        last_next = second;
        err_next  = 1'b0;
        end_next  = second && head_entry.fin;
      end
      default: begin
        unit_next = head_entry.unit_hi;
        last_next = 1'b1;
        err_next  = 1'b0;
        end_next  = head_entry.fin;
      end
    endcase
  end

  // Output register and pair phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (take) begin
        second <= (head_entry.kind == u8u16_pkg::KIND_PAIR) && !second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_unit  <= unit_next;
      run_last   <= last_next;
      error      <= err_next;
      stream_end <= end_next;
    end
  end

endmodule

@@ src/utf8_to_utf16_transcoder.sv @@
// Top level of the UTF-8 to UTF-16 transcoder.
// Takes one UTF-8 byte per cycle and gives UTF-16 code units, one per cycle while
// the receiver is ready. A byte is taken whenever the entry queue between the
// decoder and the output stage has room. A result passes from the decoder through
// the entry queue into the output register. Four-byte characters give a surrogate
// pair, which the output stage sends as two units, but that pair comes from four
// input bytes. The output stage therefore never falls behind a byte a cycle, and
// the input runs back to back for as long as results are drained. The queue fills,
// and s_tready drops, only while the receiver holds the output off.
// An error gives one result with the error flag, then bytes are dropped up to
// and including the one marked final.
module utf8_to_utf16_transcoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tlast,    // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [15:0] code_unit, [16] stream_end, [23:17] zero
  output logic        m_tlast,    // run_last
  output logic        m_tuser     // error
);

  logic              push, pop, full, head_valid;
  u8u16_pkg::entry_t push_entry, head_entry;
  logic [15:0]       code_unit;
  logic              stream_end;

  u8u16_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .byte_ready (s_tready),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .queue_full (full),
    .push       (push),
    .push_entry (push_entry)
  );

  u8u16_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  u8u16_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .code_unit  (code_unit),
    .run_last   (m_tlast),
    .error      (m_tuser),
    .stream_end (stream_end)
  );

  assign m_tdata = {7'd0, stream_end, code_unit};

endmodule

@@ src/u8u16_checker.sv @@
// Port-level checks on the transcoder output, bound to the top level.
module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // A stalled item holds still
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output item changed while stalled");

  // An error item carries a zero unit and closes both the run and the stream
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:0] == 16'd0 && m_tlast && m_tdata[16])
    else $error("malformed error item");

  // The end of a stream is always the end of a run
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> m_tlast)
    else $error("stream end without run end");

  // Only a high surrogate is followed by another item of the same character,
  // and the next item taken is then a low surrogate
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[15:10] == u8u16_pkg::HIGH_SURR_PREFIX && !m_tuser)
    else $error("non-final item is not a high surrogate");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid
                                         && m_tdata[15:10] == u8u16_pkg::LOW_SURR_PREFIX)
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

@@ tb/utf8_to_utf16_transcoder_test.sv @@
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL     = 300;

  // One UTF-8 input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } utf8_byte_t;

  // One UTF-16 result
  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        error;
    logic        stream_end;
  } utf16_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tlast = 1'b0;    // final_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [15:0] code_unit, [16] stream_end, [23:17] zero
  logic        m_tlast;           // run_last
  logic        m_tuser;           // error

  utf8_byte_t    pending_bytes[$];
  utf16_result_t expected_units[$];
  logic [7:0]    stream_bytes[$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   bytes_queued  = 0;
  int   bytes_taken   = 0;
  int   error_count   = 0;
  int   quiet_cycles  = 0;
  int   rx_stall_cnt  = 0;
  logic rx_stall_go   = 1'b0;
  logic rx_stall_done = 1'b0;
  logic in_taken      = 1'b0;

  // Predictor state
  logic [20:0] partial_point   = '0;
  logic [1:0]  bytes_due       = '0;
  logic [1:0]  sequence_length = '0;
  logic        discarding      = 1'b0;

  utf8_to_utf16_transcoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  task automatic clear_sequence();
    partial_point   = '0;
    bytes_due       = '0;
    sequence_length = '0;
  endtask

  task automatic expect_error(input logic is_final);
    utf16_result_t r;
    clear_sequence();
    discarding = !is_final;
    r = '{code_unit: 16'h0000, run_last: 1'b1, error: 1'b1, stream_end: 1'b1};
    expected_units.push_back(r);
  endtask

  // One unit, or a surrogate pair with the high half first
  task automatic expect_point(input logic [20:0] cp, input logic is_final);
    utf16_result_t r;
    logic [19:0]   v;
    clear_sequence();
    if (cp < u8u16_pkg::CP_MIN_4BYTE) begin
      r = '{code_unit: cp[15:0], run_last: 1'b1, error: 1'b0, stream_end: is_final};
      expected_units.push_back(r);
    end else begin
      v = 20'(cp - u8u16_pkg::CP_MIN_4BYTE);
      r = '{code_unit: {u8u16_pkg::HIGH_SURR_PREFIX, v[19:10]}, run_last: 1'b0,
            error: 1'b0, stream_end: 1'b0};
      expected_units.push_back(r);
      r = '{code_unit: {u8u16_pkg::LOW_SURR_PREFIX, v[9:0]}, run_last: 1'b1,
            error: 1'b0, stream_end: is_final};
      expected_units.push_back(r);
    end
  endtask

  task automatic decode_utf8_byte(input logic [7:0] b, input logic is_final);
    logic [20:0] cp;
    if (discarding) begin
      if (is_final) begin
        discarding = 1'b0;
        clear_sequence();
      end
      return;
    end
    // lead byte
    if (bytes_due == 2'd0) begin
      if (b < 8'h80) begin
        expect_point({13'd0, b}, is_final);
        return;
      end
      if (b >= u8u16_pkg::LEAD2_LOW && b <= u8u16_pkg::LEAD2_HIGH) begin
        partial_point = {16'd0, b[4:0]};
        bytes_due = 2'd1;
        sequence_length = 2'd1;
      end else if (b >= u8u16_pkg::LEAD3_LOW && b <= u8u16_pkg::LEAD3_HIGH) begin
        partial_point = {17'd0, b[3:0]};
        bytes_due = 2'd2;
        sequence_length = 2'd2;
      end else if (b >= u8u16_pkg::LEAD4_LOW && b <= u8u16_pkg::LEAD4_HIGH) begin
        partial_point = {18'd0, b[2:0]};
        bytes_due = 2'd3;
        sequence_length = 2'd3;
      end else begin
        expect_error(is_final);
        return;
      end
      if (is_final) expect_error(is_final);
      return;
    end
    // continuation byte
    if (b[7:6] != 2'b10) begin
      expect_error(is_final);
      return;
    end
    partial_point = {partial_point[14:0], b[5:0]};
    bytes_due = bytes_due - 2'd1;
    if (bytes_due != 2'd0) begin
      if (is_final) expect_error(is_final);
      return;
    end
    cp = partial_point;
    if (sequence_length == 2'd2 &&
        (cp < u8u16_pkg::CP_MIN_3BYTE ||
         (cp >= u8u16_pkg::CP_SURR_LOW && cp <= u8u16_pkg::CP_SURR_HIGH)))
      expect_error(is_final);
    else if (sequence_length == 2'd3 &&
             (cp < u8u16_pkg::CP_MIN_4BYTE || cp > u8u16_pkg::CP_MAX))
      expect_error(is_final);
    else
      expect_point(cp, is_final);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic queue_byte(input logic [7:0] b, input logic is_final);
    utf8_byte_t item;
    item.data_byte  = b;
    item.final_byte = is_final;
    pending_bytes.push_back(item);
    bytes_queued++;
  endtask

  // Encode any 21-bit value at a given length, overlong and out-of-range forms too
  task automatic encode_point(input logic [20:0] cp, input int len);
    case (len)
      1: stream_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        stream_bytes.push_back({3'b110, cp[10:6]});
        stream_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        stream_bytes.push_back({4'b1110, cp[15:12]});
        stream_bytes.push_back({2'b10, cp[11:6]});
        stream_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        stream_bytes.push_back({5'b11110, cp[20:18]});
        stream_bytes.push_back({2'b10, cp[17:12]});
        stream_bytes.push_back({2'b10, cp[11:6]});
        stream_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic encode_valid(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= u8u16_pkg::CP_SURR_LOW && cp <= u8u16_pkg::CP_SURR_HIGH)
          cp = cp - 21'h800;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    encode_point(cp, len);
  endtask

  // Mostly well-formed streams, with noise and broken sequences mixed in
  task automatic add_random_stream();
    int         n_chars;
    int         len;
    int         cut;
    logic [7:0] b;
    stream_bytes.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 7)) stream_bytes.push_back(8'($urandom_range(255)));
    end else begin
      n_chars = $urandom_range(1, 10);
      for (int i = 0; i < n_chars; i++) begin
        len = $urandom_range(1, 4);
        if ($urandom_range(99) >= 7) begin
          encode_valid(len);
          continue;
        end
        case ($urandom_range(0, 7))
          0: stream_bytes.push_back($urandom_range(1) ? 8'($urandom_range('h80, 'hC1))
                                                      : 8'($urandom_range('hF5, 'hFF)));
          1: begin
            // bad continuation somewhere in a multi-byte form
            len = $urandom_range(2, 4);
            encode_valid(len);
            b = 8'($urandom_range(255));
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            stream_bytes[stream_bytes.size() - $urandom_range(1, len - 1)] = b;
          end
          2: encode_point(21'($urandom_range(0, 'h7F)), 2);
          3: encode_point(21'($urandom_range(0, 'h7FF)), 3);
          4: encode_point(21'($urandom_range('hD800, 'hDFFF)), 3);
          5: encode_point(21'($urandom_range(0, 'hFFFF)), 4);
          6: encode_point(21'($urandom_range('h110000, 'h1FFFFF)), 4);
          default: begin
            // stream cut off inside a sequence
            len = $urandom_range(2, 4);
            encode_valid(len);
            cut = $urandom_range(1, len - 1);
            repeat (cut) void'(stream_bytes.pop_back());
            break;
          end
        endcase
      end
    end
    foreach (stream_bytes[i]) queue_byte(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  task automatic add_random_bytes(input int target);
    int start_count;
    start_count = bytes_queued;
    while (bytes_queued - start_count < target) add_random_stream();
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || expected_units.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Input acceptance feeds the predictor; output items are checked in order
  always @(posedge clk) begin
    utf16_result_t want;
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      decode_utf8_byte(s_tdata, s_tlast);
      bytes_taken++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_units.size() == 0) begin
        report_mismatch("result with nothing expected, code_unit", m_tdata[15:0], 16'h0);
      end else begin
        want = expected_units.pop_front();
        if (m_tdata[15:0] !== want.code_unit)
          report_mismatch("code_unit", m_tdata[15:0], want.code_unit);
        if (m_tlast !== want.run_last)
          report_mismatch("run_last", {15'd0, m_tlast}, {15'd0, want.run_last});
        if (m_tuser !== want.error)
          report_mismatch("error", {15'd0, m_tuser}, {15'd0, want.error});
        if (m_tdata[16] !== want.stream_end)
          report_mismatch("stream_end", {15'd0, m_tdata[16]}, {15'd0, want.stream_end});
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving

  // Sender: holds an offered item until it is taken
  always @(negedge clk) begin
    utf8_byte_t next_byte;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = pending_bytes.pop_front();
        s_tdata  <= next_byte.data_byte;
        s_tlast  <= next_byte.final_byte;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_stall_go && !rx_stall_done) begin
      m_tready <= 1'b0;
      rx_stall_cnt++;
      if (rx_stall_cnt >= LONG_STALL) rx_stall_done = 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles lightly, receiver heavily
    send_idle_pct = 16;
    recv_idle_pct = 71;
    // extremes of each valid form
    queue_byte(8'h00, 1'b0); queue_byte(8'h7F, 1'b0);
    queue_byte(8'hDF, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hE0, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hF4, 1'b0); queue_byte(8'h8F, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b1);
    // bad lead, then bytes dropped up to the final one
    queue_byte(8'h80, 1'b0); queue_byte(8'hFF, 1'b1);
    queue_byte(8'hF5, 1'b1);
    // bad continuation
    queue_byte(8'hC2, 1'b0); queue_byte(8'h41, 1'b1);
    // overlong three-byte form
    queue_byte(8'hE0, 1'b0); queue_byte(8'h9F, 1'b0); queue_byte(8'hBF, 1'b1);
    // encoded surrogate
    queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b1);
    // above the last code point
    queue_byte(8'hF4, 1'b0); queue_byte(8'h90, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b1);
    // stream ends inside a sequence
    queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b1);
    add_random_bytes(420);
    wait_drained();

    // Sender idles heavily, receiver lightly
    send_idle_pct = 71;
    recv_idle_pct = 16;
    add_random_bytes(450);
    wait_drained();

    // No idling; one long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_bytes(60);
    rx_stall_go = 1'b1;
    wait (rx_stall_done);
    @(posedge clk);
    rx_stall_go = 1'b0;
    add_random_bytes(400);
    wait_drained();

    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
